/* design/rdm_pkg.sv */
// Shared types and constants of the radial distortion mapper.
package rdm_pkg;

    // Field widths.
    localparam int COORD_W    = 20;
    localparam int SCALE_W    = 18;
    localparam int COEF_W     = 32;
    localparam int INV_W      = 24;
    localparam int DX_W       = 31;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_X     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_Y     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_K2     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_K4     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_SCALE_X = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_SCALE_Y = 3'd7;

    // Reset value of the scale registers (1.0 in Q2.16 and Q8.16).
    localparam logic [SCALE_W-1:0] SCALE_ONE     = 18'd65536;
    localparam logic [INV_W-1:0]   INV_SCALE_ONE = 24'd65536;

    // Largest output coordinate.
    localparam logic [COORD_W-1:0] COORD_MAX = 20'hFFFFF;

    // Configuration register set.
    typedef struct packed {
        logic        [COORD_W-1:0] center_x;
        logic        [COORD_W-1:0] center_y;
        logic        [SCALE_W-1:0] scale_x;
        logic        [SCALE_W-1:0] scale_y;
        logic signed [COEF_W-1:0]  coef_k2;
        logic signed [COEF_W-1:0]  coef_k4;
        logic        [INV_W-1:0]   inv_scale_x;
        logic        [INV_W-1:0]   inv_scale_y;
    } t_rdm_cfg;

    // Scaled offsets and correction factor passed to the remap stages.
    typedef struct packed {
        logic signed [DX_W-1:0]   dx;
        logic signed [DX_W-1:0]   dy;
        logic signed [COEF_W-1:0] corr;
        logic                     clip;
    } t_rdm_radius;

endpackage

/* design/radial_distortion_mapper_core.sv */
// Top level of the radial distortion mapper.
//
// The block maps one source point to its radially distorted position.
// A point enters as a transaction on the s_axis channel (x in the low 20
// bits of tdata, y above it, both Q12.8). The result leaves as a transaction
// on the m_axis channel with mapped x and y in tdata and the clipped flag in
// tuser. Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata
// only while no point is in flight, a rule on the user that the block itself
// does not enforce; a write takes effect at the next edge. Throughput is one
// point per clock while the receiver is ready. From acceptance to m_axis_tvalid
// a point passes seven stages in the radius pipeline (offset and scale, square,
// radius, r2 products, r4 and k2 term, k4 product, correction) and three in the
// remap pipeline (correction product, inverse scale, rounding and saturation).
// Reset empties both pipelines and loads the register reset values.
// When the receiver stalls, each stage holds its item until the next one
// frees up, so bubbles are squeezed out and nothing is dropped or repeated;
// s_axis_tready falls only when all ten stages are full.
module radial_distortion_mapper_core import rdm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,   // point_x[19:0], point_y[39:20]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // mapped_x[19:0], mapped_y[39:20]
    output logic                  m_axis_tuser    // clipped
);

    t_rdm_cfg           w_cfg;
    t_rdm_radius        w_item;
    logic               w_item_valid;
    logic               w_item_ready;
    logic [COORD_W-1:0] w_mapped_x, w_mapped_y;

    // Configuration registers.
    rdm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Offsets, radius and correction factor.
    rdm_radius_pipe u_radius (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_point_x (s_axis_tdata[19:0]),
        .i_point_y (s_axis_tdata[39:20]),
        .o_valid   (w_item_valid),
        .i_ready   (w_item_ready),
        .o_item    (w_item)
    );

    // Correction, rescaling and saturation.
    rdm_remap_pipe u_remap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_item_valid),
        .o_ready    (w_item_ready),
        .i_item     (w_item),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_mapped_x (w_mapped_x),
        .o_mapped_y (w_mapped_y),
        .o_clipped  (m_axis_tuser)
    );

    assign m_axis_tdata = {w_mapped_y, w_mapped_x};

`ifndef SYNTH
    // A ready receiver lets every stage move, so the input is ready too.
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while the output side is ready");
`endif

endmodule

/* design/rdm_cfg_regs.sv */
// Configuration register file of the radial distortion mapper.
module rdm_cfg_regs import rdm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_rdm_cfg              o_cfg
);

    t_rdm_cfg r_cfg;

    // Each write keeps only the low bits of the register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x    <= '0;
            r_cfg.center_y    <= '0;
            r_cfg.scale_x     <= SCALE_ONE;
            r_cfg.scale_y     <= SCALE_ONE;
            r_cfg.coef_k2     <= '0;
            r_cfg.coef_k4     <= '0;
            r_cfg.inv_scale_x <= INV_SCALE_ONE;
            r_cfg.inv_scale_y <= INV_SCALE_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CENTER_X:    r_cfg.center_x    <= i_cfg_wdata[COORD_W-1:0];
                REG_CENTER_Y:    r_cfg.center_y    <= i_cfg_wdata[COORD_W-1:0];
                REG_SCALE_X:     r_cfg.scale_x     <= i_cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Y:     r_cfg.scale_y     <= i_cfg_wdata[SCALE_W-1:0];
                REG_COEF_K2:     r_cfg.coef_k2     <= $signed(i_cfg_wdata[COEF_W-1:0]);
                REG_COEF_K4:     r_cfg.coef_k4     <= $signed(i_cfg_wdata[COEF_W-1:0]);
                REG_INV_SCALE_X: r_cfg.inv_scale_x <= i_cfg_wdata[INV_W-1:0];
                REG_INV_SCALE_Y: r_cfg.inv_scale_y <= i_cfg_wdata[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/rdm_radius_pipe.sv */
// Seven-stage pipeline from a point to its scaled offsets and correction factor.
module rdm_radius_pipe import rdm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rdm_cfg           i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    output logic               o_valid,
    input  logic               i_ready,
    output t_rdm_radius        o_item
);

    localparam int NSTG = 7;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] n_vld;
    logic [NSTG:1] w_en;

    // Stage registers.
    logic signed [38:0]       r_prod_x, r_prod_y;
    logic signed [DX_W-1:0]   r_dx [2:NSTG];
    logic signed [DX_W-1:0]   r_dy [2:NSTG];
    logic        [59:0]       r_sq_x, r_sq_y;
    logic        [31:0]       r_r2;
    logic        [63:0]       r_r2sq;
    logic signed [63:0]       r_k2r2;
    logic        [31:0]       r_r4;
    logic signed [35:0]       r_t2 [5:6];
    logic signed [63:0]       r_k4r4;
    logic signed [COEF_W-1:0] r_corr;
    logic                     r_clip [3:NSTG];

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign n_vld   = {r_vld[NSTG-1:1], i_valid};
    assign o_ready = w_en[1];
    assign o_valid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 1: offset from the centre times the normalizing scale.
    logic signed [20:0] w_d_x, w_d_y;
    logic signed [39:0] w_prod_x, w_prod_y;
    assign w_d_x    = $signed({1'b0, i_point_x}) - $signed({1'b0, i_cfg.center_x});
    assign w_d_y    = $signed({1'b0, i_point_y}) - $signed({1'b0, i_cfg.center_y});
    assign w_prod_x = w_d_x * $signed({1'b0, i_cfg.scale_x});
    assign w_prod_y = w_d_y * $signed({1'b0, i_cfg.scale_y});

    // Stage 2: round to Q.16 and square.
    logic signed [38:0]     w_rnd_x, w_rnd_y;
    logic signed [DX_W-1:0] w_dx, w_dy;
    logic signed [61:0]     w_sq_x, w_sq_y;
    assign w_rnd_x = r_prod_x + 39'sd128;
    assign w_rnd_y = r_prod_y + 39'sd128;
    assign w_dx    = $signed(w_rnd_x[38:8]);
    assign w_dy    = $signed(w_rnd_y[38:8]);
    assign w_sq_x  = w_dx * w_dx;
    assign w_sq_y  = w_dy * w_dy;

    // Stage 3: squared radius in Q.28, saturated to 32 bits.
    logic [61:0] w_sum;
    logic        w_r2_sat;
    assign w_sum    = {2'b00, r_sq_x} + {2'b00, r_sq_y} + 62'd8;
    assign w_r2_sat = |w_sum[61:36];

    // Stage 5: fourth power of the radius, and the rounded k2 term.
    logic [64:0]        w_r4_rnd;
    logic               w_r4_sat;
    logic signed [63:0] w_k2_rnd;
    assign w_r4_rnd = {1'b0, r_r2sq} + 65'd134217728;
    assign w_r4_sat = |w_r4_rnd[64:60];
    assign w_k2_rnd = r_k2r2 + 64'sd134217728;

    // Stage 7: correction factor, saturated to signed 32 bits.
    logic signed [63:0] w_k4_rnd;
    logic signed [35:0] w_t4;
    logic signed [37:0] w_corr_sum;
    logic               w_corr_hi, w_corr_lo;
    assign w_k4_rnd   = r_k4r4 + 64'sd134217728;
    assign w_t4       = $signed(w_k4_rnd[63:28]);
    assign w_corr_sum = 38'sd268435456 + r_t2[6] + w_t4;
    assign w_corr_hi  = w_corr_sum > 38'sd2147483647;
    assign w_corr_lo  = w_corr_sum < -38'sd2147483648;

    // Payload registers, each loaded when its stage moves.
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_prod_x <= w_prod_x[38:0];
            r_prod_y <= w_prod_y[38:0];
        end
        if (w_en[2]) begin
            r_dx[2] <= w_dx;
            r_dy[2] <= w_dy;
            r_sq_x  <= w_sq_x[59:0];
            r_sq_y  <= w_sq_y[59:0];
        end
        for (int k = 3; k <= NSTG; k++) begin
            if (w_en[k]) begin
                r_dx[k] <= r_dx[k-1];
                r_dy[k] <= r_dy[k-1];
            end
        end
        if (w_en[3]) begin
            r_r2    <= w_r2_sat ? 32'hFFFFFFFF : w_sum[35:4];
            r_clip[3] <= w_r2_sat;
        end
        if (w_en[4]) begin
            r_r2sq    <= r_r2 * r_r2;
            r_k2r2    <= i_cfg.coef_k2 * $signed({1'b0, r_r2});
            r_clip[4] <= r_clip[3];
        end
        if (w_en[5]) begin
            r_r4      <= w_r4_sat ? 32'hFFFFFFFF : w_r4_rnd[59:28];
            r_t2[5]   <= $signed(w_k2_rnd[63:28]);
            r_clip[5] <= r_clip[4] || w_r4_sat;
        end
        if (w_en[6]) begin
            r_k4r4    <= i_cfg.coef_k4 * $signed({1'b0, r_r4});
            r_t2[6]   <= r_t2[5];
            r_clip[6] <= r_clip[5];
        end
        if (w_en[7]) begin
            priority if (w_corr_hi) begin
                r_corr <= 32'sh7FFFFFFF;
            end else if (w_corr_lo) begin
                r_corr <= 32'sh80000000;
            end else begin
                r_corr <= $signed(w_corr_sum[31:0]);
            end
            r_clip[7] <= r_clip[6] || w_corr_hi || w_corr_lo;
        end
    end

    assign o_item.dx   = r_dx[NSTG];
    assign o_item.dy   = r_dy[NSTG];
    assign o_item.corr = r_corr;
    assign o_item.clip = r_clip[NSTG];

`ifndef SYNTH
    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("radius pipe holds an item right after reset");

    // The input side only stalls when every stage is full and the output is stalled.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("radius pipe stalls its input with room left");
`endif

endmodule

/* design/rdm_remap_pipe.sv */
// Three-stage pipeline that applies the correction, rescales and saturates.
module rdm_remap_pipe import rdm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_rdm_cfg           i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_rdm_radius        i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_mapped_x,
    output logic [COORD_W-1:0] o_mapped_y,
    output logic               o_clipped
);

    localparam int NSTG = 3;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] n_vld;
    logic [NSTG:1] w_en;

    logic signed [62:0]  r_pe_x, r_pe_y;
    logic signed [59:0]  r_pm_x, r_pm_y;
    logic                r_clip [1:2];
    logic [COORD_W-1:0]  r_mx, r_my;
    logic                r_clipped;

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign n_vld   = {r_vld[NSTG-1:1], i_valid};
    assign o_ready = w_en[1];
    assign o_valid = r_vld[NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 1: offsets times the correction factor.
    logic signed [62:0] w_pe_x, w_pe_y;
    assign w_pe_x = i_item.dx * i_item.corr;
    assign w_pe_y = i_item.dy * i_item.corr;

    // Stage 2: round back to Q.16 and multiply by the inverse scale.
    logic signed [62:0] w_e_rnd_x, w_e_rnd_y;
    logic signed [34:0] w_e_x, w_e_y;
    logic signed [59:0] w_pm_x, w_pm_y;
    assign w_e_rnd_x = r_pe_x + 63'sd134217728;
    assign w_e_rnd_y = r_pe_y + 63'sd134217728;
    assign w_e_x     = $signed(w_e_rnd_x[62:28]);
    assign w_e_y     = $signed(w_e_rnd_y[62:28]);
    assign w_pm_x    = w_e_x * $signed({1'b0, i_cfg.inv_scale_x});
    assign w_pm_y    = w_e_y * $signed({1'b0, i_cfg.inv_scale_y});

    // Stage 3: round to Q.8, add the centre back and saturate.
    logic signed [59:0] w_m_rnd_x, w_m_rnd_y;
    logic signed [36:0] w_m_x, w_m_y;
    logic               w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    assign w_m_rnd_x = r_pm_x + 60'sd8388608;
    assign w_m_rnd_y = r_pm_y + 60'sd8388608;
    assign w_m_x     = $signed(w_m_rnd_x[59:24]) + $signed({1'b0, i_cfg.center_x});
    assign w_m_y     = $signed(w_m_rnd_y[59:24]) + $signed({1'b0, i_cfg.center_y});
    assign w_lo_x    = w_m_x < 37'sd0;
    assign w_hi_x    = w_m_x > $signed({17'd0, COORD_MAX});
    assign w_lo_y    = w_m_y < 37'sd0;
    assign w_hi_y    = w_m_y > $signed({17'd0, COORD_MAX});

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_pe_x    <= w_pe_x;
            r_pe_y    <= w_pe_y;
            r_clip[1] <= i_item.clip;
        end
        if (w_en[2]) begin
            r_pm_x    <= w_pm_x;
            r_pm_y    <= w_pm_y;
            r_clip[2] <= r_clip[1];
        end
        if (w_en[3]) begin
            priority if (w_lo_x) begin
                r_mx <= '0;
            end else if (w_hi_x) begin
                r_mx <= COORD_MAX;
            end else begin
                r_mx <= w_m_x[COORD_W-1:0];
            end
            priority if (w_lo_y) begin
                r_my <= '0;
            end else if (w_hi_y) begin
                r_my <= COORD_MAX;
            end else begin
                r_my <= w_m_y[COORD_W-1:0];
            end
            r_clipped <= r_clip[2] || w_lo_x || w_hi_x || w_lo_y || w_hi_y;
        end
    end

    assign o_mapped_x = r_mx;
    assign o_mapped_y = r_my;
    assign o_clipped  = r_clipped;

`ifndef SYNTH
    // The input side only stalls when every stage is full and the output is stalled.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("remap pipe stalls its input with room left");
`endif

endmodule
